FILE: sv/rmfd_pkg.sv
// shared types, constants and register codes for the rfid manchester frame decoder
package rmfd_pkg;

  localparam int FRAME_BITS = 64;
  localparam int TIME_W = 16;
  localparam int RUN_W = 8;
  localparam int HELD_W = 7;
  localparam int FRAME_W = 64;
  localparam int CFG_IDX_W = 3;
  localparam int CFG_DATA_W = 16;
  localparam int IN_DATA_W = 32;
  localparam int OUT_DATA_W = 80;

  localparam logic [TIME_W-1:0] HIGH_MIN_RST = 16'd236;
  localparam logic [TIME_W-1:0] HIGH_SPLIT_RST = 16'd676;
  localparam logic [TIME_W-1:0] HIGH_MAX_RST = 16'd1192;
  localparam logic [TIME_W-1:0] GAP_MIN_RST = 16'd346;
  localparam logic [TIME_W-1:0] GAP_SPLIT_RST = 16'd786;
  localparam logic [TIME_W-1:0] GAP_MAX_RST = 16'd1300;
  localparam logic [RUN_W-1:0] HEADER_NEEDED_RST = 8'd9;
  localparam logic [RUN_W-1:0] RUN_SAT = 8'd255;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_HIGH_MIN = 3'd0,
    REG_HIGH_SPLIT = 3'd1,
    REG_HIGH_MAX = 3'd2,
    REG_GAP_MIN = 3'd3,
    REG_GAP_SPLIT = 3'd4,
    REG_GAP_MAX = 3'd5,
    REG_HEADER_NEEDED = 3'd6
  } cfg_reg_t;

  typedef enum logic [1:0] {
    CLS_NOISE = 2'd0,
    CLS_ONE = 2'd1,
    CLS_TWO = 2'd2
  } class_t;

  typedef struct packed {
    logic [TIME_W-1:0] lo;
    logic [TIME_W-1:0] split;
    logic [TIME_W-1:0] hi;
  } bounds_t;

endpackage

FILE: sv/rmfd_classify.sv
// classes one pulse time as noise, one T or two T against a set of bounds
module rmfd_classify (
  input  logic [rmfd_pkg::TIME_W-1:0] tval,
  input  rmfd_pkg::bounds_t           bounds,
  output rmfd_pkg::class_t            cls
);

  always_comb begin
    if (tval < bounds.lo || tval > bounds.hi) begin
      cls = rmfd_pkg::CLS_NOISE;
    end else if (tval < bounds.split) begin
      cls = rmfd_pkg::CLS_ONE;
    end else begin
      cls = rmfd_pkg::CLS_TWO;
    end
  end

endmodule

FILE: sv/rfid_manchester_frame_decoder_core.sv
// top level of the rfid manchester frame decoder: header hunt, half-symbol feed, frame output
//
// s_* channel: one pulse capture per transfer, period and high time in timer ticks.
// m_* channel: exactly one result per capture, in order; m_tlast flags the capture
//   that completed a frame, and only then does the frame field carry the bits.
// cfg_* channel: register writes, index 0..6, always ready; write only while idle.
// Path: an accepted capture lands in the input register, and its result is
//   registered in the output register once that is empty or being taken.
// Throughput: one capture per cycle while m_tready stays high; the decoder state
//   is updated in the same cycle the result register is loaded.
// Stall: while m_tready is low the result holds; the input register still takes
//   one more capture, then s_tready drops until the result is taken.
// Reset: rst clears both valid flags, the header run, data mode, the phase, the
//   bit count and the bit store, and loads the default bounds and header length.
module rfid_manchester_frame_decoder_core #(
  parameter int FRAME_BITS = rmfd_pkg::FRAME_BITS
) (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              s_tvalid,
  output logic                              s_tready,
  // period [15:0], high_time [31:16]
  input  logic [rmfd_pkg::IN_DATA_W-1:0]    s_tdata,
  output logic                              m_tvalid,
  input  logic                              m_tready,
  // high_class [1:0], low_class [3:2], start_seen [4], receiving [5],
  // bits_held [12:6], frame [76:13], zero [79:77]
  output logic [rmfd_pkg::OUT_DATA_W-1:0]   m_tdata,
  // frame_valid
  output logic                              m_tlast,
  input  logic                              cfg_valid,
  output logic                              cfg_ready,
  input  logic [rmfd_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  logic [rmfd_pkg::CFG_DATA_W-1:0]   cfg_data
);

  localparam int CNT_W = $clog2(FRAME_BITS + 1);
  localparam logic [CNT_W-1:0] FULL = CNT_W'(FRAME_BITS);

  rmfd_pkg::bounds_t high_bounds;
  rmfd_pkg::bounds_t gap_bounds;
  logic [rmfd_pkg::RUN_W-1:0] header_needed;

  logic in_valid;
  logic [rmfd_pkg::TIME_W-1:0] in_period;
  logic [rmfd_pkg::TIME_W-1:0] in_high;
  logic advance;

  logic [rmfd_pkg::RUN_W-1:0] header_run, header_run_next;
  logic in_data, in_data_next;
  logic half_phase, half_phase_next;
  logic [CNT_W-1:0] bit_total, bit_total_next;
  logic [FRAME_BITS-1:0] bit_store, bit_store_next;

  logic [rmfd_pkg::TIME_W-1:0] low_time;
  rmfd_pkg::class_t hc_raw, lc_raw, hc, lc;
  logic start, done;
  logic [3:0] half_en;

  logic [rmfd_pkg::OUT_DATA_W-1:0] out_data_next;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      high_bounds <= '{rmfd_pkg::HIGH_MIN_RST, rmfd_pkg::HIGH_SPLIT_RST,
                       rmfd_pkg::HIGH_MAX_RST};
      gap_bounds <= '{rmfd_pkg::GAP_MIN_RST, rmfd_pkg::GAP_SPLIT_RST,
                      rmfd_pkg::GAP_MAX_RST};
      header_needed <= rmfd_pkg::HEADER_NEEDED_RST;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        rmfd_pkg::REG_HIGH_MIN:      high_bounds.lo <= cfg_data;
        rmfd_pkg::REG_HIGH_SPLIT:    high_bounds.split <= cfg_data;
        rmfd_pkg::REG_HIGH_MAX:      high_bounds.hi <= cfg_data;
        rmfd_pkg::REG_GAP_MIN:       gap_bounds.lo <= cfg_data;
        rmfd_pkg::REG_GAP_SPLIT:     gap_bounds.split <= cfg_data;
        rmfd_pkg::REG_GAP_MAX:       gap_bounds.hi <= cfg_data;
        rmfd_pkg::REG_HEADER_NEEDED: header_needed <= cfg_data[rmfd_pkg::RUN_W-1:0];
        default: ;
      endcase
    end
  end

  assign advance = in_valid && (!m_tvalid || m_tready);
  assign s_tready = !in_valid || advance;

  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (s_tready) begin
      in_valid <= s_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (s_tvalid && s_tready) begin
      in_period <= s_tdata[15:0];
      in_high <= s_tdata[31:16];
    end
  end

  assign low_time = in_period - in_high;

  rmfd_classify u_high_cls (
    .tval   (in_high),
    .bounds (high_bounds),
    .cls    (hc_raw)
  );

  rmfd_classify u_gap_cls (
    .tval   (low_time),
    .bounds (gap_bounds),
    .cls    (lc_raw)
  );

  always_comb begin
    header_run_next = header_run;
    in_data_next = in_data;
    half_phase_next = half_phase;
    bit_total_next = bit_total;
    bit_store_next = bit_store;
    start = 1'b0;
    done = 1'b0;
    hc = rmfd_pkg::CLS_NOISE;
    lc = rmfd_pkg::CLS_NOISE;
    half_en = 4'b0000;
    if (in_period != '0) begin
      hc = hc_raw;
      lc = lc_raw;
      if (hc == rmfd_pkg::CLS_TWO && lc == rmfd_pkg::CLS_ONE) begin
        header_run_next = rmfd_pkg::RUN_W'(1);
      end else if (hc == rmfd_pkg::CLS_ONE && lc == rmfd_pkg::CLS_ONE) begin
        if (header_run != rmfd_pkg::RUN_SAT) begin
          header_run_next = header_run + 1'b1;
        end
      end else if (hc == rmfd_pkg::CLS_ONE && lc == rmfd_pkg::CLS_TWO &&
                   header_run >= header_needed) begin
        header_run_next = '0;
        bit_store_next = '0;
        bit_total_next = '0;
        half_phase_next = 1'b0;
        in_data_next = 1'b1;
        start = 1'b1;
      end else begin
        header_run_next = '0;
      end
      if (in_data_next) begin
        if (hc == rmfd_pkg::CLS_NOISE || lc == rmfd_pkg::CLS_NOISE) begin
          in_data_next = 1'b0;
        end else begin
          half_en = {lc == rmfd_pkg::CLS_TWO, 1'b1, hc == rmfd_pkg::CLS_TWO, 1'b1};
        end
      end
    end
    // high halves first, then low halves; every second half is a bit
    for (int i = 0; i < 4; i++) begin
      if (half_en[i] && bit_total_next != FULL) begin
        if (!half_phase_next) begin
          half_phase_next = 1'b1;
        end else begin
          half_phase_next = 1'b0;
          bit_store_next = {bit_store_next[FRAME_BITS-2:0], i >= 2};
          bit_total_next = bit_total_next + 1'b1;
          if (bit_total_next == FULL) begin
            done = 1'b1;
          end
        end
      end
    end
  end

  always_comb begin
    out_data_next = '0;
    out_data_next[1:0] = hc;
    out_data_next[3:2] = lc;
    out_data_next[4] = start;
    out_data_next[5] = in_data_next;
    out_data_next[12:6] = rmfd_pkg::HELD_W'(bit_total_next);
    if (done) begin
      out_data_next[76:13] = rmfd_pkg::FRAME_W'(bit_store_next);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      header_run <= '0;
      in_data <= 1'b0;
      half_phase <= 1'b0;
      bit_total <= '0;
      bit_store <= '0;
      m_tvalid <= 1'b0;
    end else begin
      if (advance) begin
        header_run <= header_run_next;
        in_data <= in_data_next;
        half_phase <= half_phase_next;
        bit_total <= bit_total_next;
        bit_store <= bit_store_next;
        m_tvalid <= 1'b1;
      end else if (m_tready) begin
        m_tvalid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      m_tdata <= out_data_next;
      m_tlast <= done;
    end
  end

  a_full_on_last: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && m_tlast |-> m_tdata[12:6] == rmfd_pkg::HELD_W'(FRAME_BITS))
    else $error("frame flagged without a full bit count");

  a_frame_zero: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tlast |-> m_tdata[76:13] == '0)
    else $error("frame field not zero on a non-final result");

  a_start_recv: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && m_tdata[4] |-> m_tdata[5])
    else $error("start seen without data mode");

  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    bit_total <= FULL)
    else $error("bit count beyond frame length");

endmodule

FILE: dv/tb_rfid_manchester_frame_decoder_core.sv
// testbench for the rfid manchester frame decoder core: predicted decode vs result stream
`timescale 1ns / 1ps

module tb_rfid_manchester_frame_decoder_core;

  localparam int CYCLE_LIMIT = 200000;
  localparam int HOLD_CYCLES = 250;
  localparam int DRAIN_CYCLES = 8;

  typedef struct packed {
    logic [rmfd_pkg::FRAME_W-1:0] frame;
    logic frame_valid;
    logic [rmfd_pkg::HELD_W-1:0] bits_held;
    logic receiving;
    logic start_seen;
    rmfd_pkg::class_t low_class;
    rmfd_pkg::class_t high_class;
  } decode_t;

  class decode_tracker;
    rmfd_pkg::bounds_t high_bnd;
    rmfd_pkg::bounds_t gap_bnd;
    logic [rmfd_pkg::RUN_W-1:0] need_len;
    logic [rmfd_pkg::RUN_W-1:0] run_len;
    logic data_mode;
    logic half_odd;
    logic [rmfd_pkg::HELD_W-1:0] held;
    logic [rmfd_pkg::FRAME_W-1:0] store;
    decode_t pending_decodes[$];
    int fails;
    int results_checked;
    int frames_done;
    int starts_done;

    function new();
      high_bnd = '{rmfd_pkg::HIGH_MIN_RST, rmfd_pkg::HIGH_SPLIT_RST, rmfd_pkg::HIGH_MAX_RST};
      gap_bnd = '{rmfd_pkg::GAP_MIN_RST, rmfd_pkg::GAP_SPLIT_RST, rmfd_pkg::GAP_MAX_RST};
      need_len = rmfd_pkg::HEADER_NEEDED_RST;
      run_len = '0;
      data_mode = 1'b0;
      half_odd = 1'b0;
      held = '0;
      store = '0;
      fails = 0;
      results_checked = 0;
      frames_done = 0;
      starts_done = 0;
    endfunction

    function void set_reg(rmfd_pkg::cfg_reg_t idx, logic [rmfd_pkg::CFG_DATA_W-1:0] val);
      case (idx)
        rmfd_pkg::REG_HIGH_MIN: high_bnd.lo = val;
        rmfd_pkg::REG_HIGH_SPLIT: high_bnd.split = val;
        rmfd_pkg::REG_HIGH_MAX: high_bnd.hi = val;
        rmfd_pkg::REG_GAP_MIN: gap_bnd.lo = val;
        rmfd_pkg::REG_GAP_SPLIT: gap_bnd.split = val;
        rmfd_pkg::REG_GAP_MAX: gap_bnd.hi = val;
        rmfd_pkg::REG_HEADER_NEEDED: need_len = val[rmfd_pkg::RUN_W-1:0];
        default: ;
      endcase
    endfunction

    function rmfd_pkg::class_t grade_time(logic [rmfd_pkg::TIME_W-1:0] t,
                                          rmfd_pkg::bounds_t b);
      if (t < b.lo || t > b.hi) return rmfd_pkg::CLS_NOISE;
      return (t < b.split) ? rmfd_pkg::CLS_ONE : rmfd_pkg::CLS_TWO;
    endfunction

    // every second half-symbol becomes a bit, nothing past a full frame
    function bit push_half(bit val);
      if (held >= rmfd_pkg::FRAME_BITS) return 1'b0;
      if (!half_odd) begin
        half_odd = 1'b1;
        return 1'b0;
      end
      half_odd = 1'b0;
      store = {store[rmfd_pkg::FRAME_W-2:0], val};
      held = held + 1'b1;
      return held == rmfd_pkg::FRAME_BITS;
    endfunction

    function void note_capture(logic [rmfd_pkg::TIME_W-1:0] per,
                               logic [rmfd_pkg::TIME_W-1:0] hi_t);
      decode_t r;
      logic [rmfd_pkg::TIME_W-1:0] lo_t;
      bit done;
      r = '0;
      done = 1'b0;
      if (per != '0) begin
        lo_t = per - hi_t;
        r.high_class = grade_time(hi_t, high_bnd);
        r.low_class = grade_time(lo_t, gap_bnd);
        if (r.high_class == rmfd_pkg::CLS_TWO && r.low_class == rmfd_pkg::CLS_ONE) begin
          run_len = 8'd1;
        end else if (r.high_class == rmfd_pkg::CLS_ONE &&
                     r.low_class == rmfd_pkg::CLS_ONE) begin
          if (run_len != rmfd_pkg::RUN_SAT) run_len = run_len + 1'b1;
        end else if (r.high_class == rmfd_pkg::CLS_ONE &&
                     r.low_class == rmfd_pkg::CLS_TWO && run_len >= need_len) begin
          run_len = '0;
          store = '0;
          held = '0;
          half_odd = 1'b0;
          data_mode = 1'b1;
          r.start_seen = 1'b1;
        end else begin
          run_len = '0;
        end
        if (data_mode) begin
          if (r.high_class == rmfd_pkg::CLS_NOISE || r.low_class == rmfd_pkg::CLS_NOISE) begin
            data_mode = 1'b0;
          end else begin
            if (push_half(1'b0)) done = 1'b1;
            if (r.high_class == rmfd_pkg::CLS_TWO) begin
              if (push_half(1'b0)) done = 1'b1;
            end
            if (push_half(1'b1)) done = 1'b1;
            if (r.low_class == rmfd_pkg::CLS_TWO) begin
              if (push_half(1'b1)) done = 1'b1;
            end
          end
        end
      end
      r.receiving = data_mode;
      r.bits_held = held;
      r.frame_valid = done;
      r.frame = done ? store : '0;
      pending_decodes.push_back(r);
    endfunction

    function void match_field(string name, logic [rmfd_pkg::FRAME_W-1:0] want,
                              logic [rmfd_pkg::FRAME_W-1:0] got);
      if (got !== want) begin
        $error("%s: expected 0x%0h, got 0x%0h", name, want, got);
        fails++;
      end
    endfunction

    function void check_result(logic [rmfd_pkg::OUT_DATA_W-1:0] d, logic last);
      decode_t e;
      if (pending_decodes.size() == 0) begin
        $error("result transfer with no capture waiting: 0x%0h", d);
        fails++;
        return;
      end
      e = pending_decodes.pop_front();
      results_checked++;
      if (e.frame_valid) frames_done++;
      if (e.start_seen) starts_done++;
      match_field("high_class", e.high_class, d[1:0]);
      match_field("low_class", e.low_class, d[3:2]);
      match_field("start_seen", e.start_seen, d[4]);
      match_field("receiving", e.receiving, d[5]);
      match_field("bits_held", e.bits_held, d[12:6]);
      match_field("frame", e.frame, d[76:13]);
      match_field("pad", '0, d[79:77]);
      match_field("frame_valid", e.frame_valid, last);
    endfunction
  endclass

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic s_tvalid = 1'b0;
  logic s_tready;
  logic [rmfd_pkg::IN_DATA_W-1:0] s_tdata = '0;
  logic m_tvalid;
  logic m_tready = 1'b0;
  logic [rmfd_pkg::OUT_DATA_W-1:0] m_tdata;
  logic m_tlast;
  logic cfg_valid = 1'b0;
  logic cfg_ready;
  logic [rmfd_pkg::CFG_IDX_W-1:0] cfg_index = '0;
  logic [rmfd_pkg::CFG_DATA_W-1:0] cfg_data = '0;

  decode_tracker sb;
  rmfd_pkg::bounds_t cur_high = '{rmfd_pkg::HIGH_MIN_RST, rmfd_pkg::HIGH_SPLIT_RST,
                                  rmfd_pkg::HIGH_MAX_RST};
  rmfd_pkg::bounds_t cur_gap = '{rmfd_pkg::GAP_MIN_RST, rmfd_pkg::GAP_SPLIT_RST,
                                 rmfd_pkg::GAP_MAX_RST};
  logic [rmfd_pkg::RUN_W-1:0] cur_need = rmfd_pkg::HEADER_NEEDED_RST;
  int send_idle_pct = 0;
  int recv_idle_pct = 0;
  int hold_requests = 0;
  int holds_done = 0;
  int hold_left = 0;
  int captures_sent = 0;
  int settings_used = 1;
  int cycle_count = 0;

  rfid_manchester_frame_decoder_core i_dut (
    .clk(clk),
    .rst(rst),
    .s_tvalid(s_tvalid),
    .s_tready(s_tready),
    .s_tdata(s_tdata),
    .m_tvalid(m_tvalid),
    .m_tready(m_tready),
    .m_tdata(m_tdata),
    .m_tlast(m_tlast),
    .cfg_valid(cfg_valid),
    .cfg_ready(cfg_ready),
    .cfg_index(cfg_index),
    .cfg_data(cfg_data)
  );

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $error("timeout after %0d cycles", cycle_count);
      $display("status: fail");
      $finish;
    end
  end

  // result sink: random stalls plus long hold-offs on request
  always @(posedge clk) begin
    if (hold_left != 0) begin
      hold_left <= hold_left - 1;
      m_tready <= 1'b0;
    end else if (holds_done != hold_requests) begin
      holds_done <= holds_done + 1;
      hold_left <= HOLD_CYCLES;
      m_tready <= 1'b0;
    end else begin
      m_tready <= ($urandom_range(99) >= recv_idle_pct);
    end
  end

  always @(posedge clk) begin
    if (!rst) begin
      if (s_tvalid && s_tready) sb.note_capture(s_tdata[15:0], s_tdata[31:16]);
      if (m_tvalid && m_tready) sb.check_result(m_tdata, m_tlast);
    end
  end

  task automatic send_capture(input logic [rmfd_pkg::TIME_W-1:0] per,
                              input logic [rmfd_pkg::TIME_W-1:0] hi_t);
    while (send_idle_pct != 0 && $urandom_range(99) < send_idle_pct) begin
      s_tvalid <= 1'b0;
      @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata <= {hi_t, per};
    @(posedge clk);
    while (!s_tready) @(posedge clk);
    captures_sent++;
  endtask

  task automatic wait_idle();
    s_tvalid <= 1'b0;
    @(posedge clk);
    while (sb.pending_decodes.size() != 0) @(posedge clk);
    repeat (3) @(posedge clk);
  endtask

  task automatic write_all(input rmfd_pkg::bounds_t hb, input rmfd_pkg::bounds_t gb,
                           input logic [rmfd_pkg::RUN_W-1:0] need);
    logic [rmfd_pkg::CFG_DATA_W-1:0] vals [7];
    int idx;
    vals[rmfd_pkg::REG_HIGH_MIN] = hb.lo;
    vals[rmfd_pkg::REG_HIGH_SPLIT] = hb.split;
    vals[rmfd_pkg::REG_HIGH_MAX] = hb.hi;
    vals[rmfd_pkg::REG_GAP_MIN] = gb.lo;
    vals[rmfd_pkg::REG_GAP_SPLIT] = gb.split;
    vals[rmfd_pkg::REG_GAP_MAX] = gb.hi;
    vals[rmfd_pkg::REG_HEADER_NEEDED] = {8'd0, need};
    wait_idle();
    for (idx = rmfd_pkg::REG_HIGH_MIN; idx <= rmfd_pkg::REG_HEADER_NEEDED; idx++) begin
      cfg_valid <= 1'b1;
      cfg_index <= rmfd_pkg::cfg_reg_t'(idx);
      cfg_data <= vals[idx];
      @(posedge clk);
      while (!cfg_ready) @(posedge clk);
      sb.set_reg(rmfd_pkg::cfg_reg_t'(idx), vals[idx]);
    end
    cfg_valid <= 1'b0;
    cur_high = hb;
    cur_gap = gb;
    cur_need = need;
    settings_used++;
  endtask

  // random time of the given class for ordered bounds, sometimes on or just beside a bound
  function automatic logic [rmfd_pkg::TIME_W-1:0] make_time(rmfd_pkg::class_t cls,
                                                            rmfd_pkg::bounds_t b);
    int unsigned lo_v;
    int unsigned sp_v;
    int unsigned hi_v;
    bit at_bound;
    lo_v = b.lo;
    sp_v = b.split;
    hi_v = b.hi;
    at_bound = ($urandom_range(7) == 0);
    case (cls)
      rmfd_pkg::CLS_ONE: begin
        if (at_bound) begin
          return ($urandom_range(1) == 0) ? b.lo : rmfd_pkg::TIME_W'(sp_v - 1);
        end
        return rmfd_pkg::TIME_W'($urandom_range(sp_v - 1, lo_v));
      end
      rmfd_pkg::CLS_TWO: begin
        if (at_bound) return ($urandom_range(1) == 0) ? b.split : b.hi;
        return rmfd_pkg::TIME_W'($urandom_range(hi_v, sp_v));
      end
      default: begin
        if (lo_v > 0 && (hi_v == 65535 || $urandom_range(1) == 0))
          return at_bound ? rmfd_pkg::TIME_W'(lo_v - 1) :
                            rmfd_pkg::TIME_W'($urandom_range(lo_v - 1, 0));
        if (hi_v < 65535)
          return at_bound ? rmfd_pkg::TIME_W'(hi_v + 1) :
                            rmfd_pkg::TIME_W'($urandom_range(65535, hi_v + 1));
        return rmfd_pkg::TIME_W'($urandom);
      end
    endcase
  endfunction

  task automatic send_pair(input rmfd_pkg::class_t hc, input rmfd_pkg::class_t lc);
    logic [rmfd_pkg::TIME_W-1:0] ht;
    logic [rmfd_pkg::TIME_W-1:0] lt;
    ht = make_time(hc, cur_high);
    lt = make_time(lc, cur_gap);
    send_capture(ht + lt, ht);
  endtask

  // one data event: mostly clean symbols, rarely noise, a zero period or a restart pattern
  task automatic send_symbol();
    int pick;
    rmfd_pkg::class_t hc;
    pick = $urandom_range(199);
    hc = rmfd_pkg::class_t'($urandom_range(2, 1));
    if (pick == 0) send_pair(rmfd_pkg::CLS_NOISE, rmfd_pkg::class_t'($urandom_range(2)));
    else if (pick == 1) send_pair(hc, rmfd_pkg::CLS_NOISE);
    else if (pick == 2) send_capture('0, rmfd_pkg::TIME_W'($urandom));
    else if (pick < 7) send_pair(rmfd_pkg::CLS_ONE, rmfd_pkg::CLS_TWO);
    else if (hc == rmfd_pkg::CLS_ONE) send_pair(rmfd_pkg::CLS_ONE, rmfd_pkg::CLS_ONE);
    else send_pair(rmfd_pkg::CLS_TWO, rmfd_pkg::class_t'($urandom_range(2, 1)));
  endtask

  task automatic send_frame(input bit broken, input int extra);
    int hdr_len;
    int body_len;
    hdr_len = int'(cur_need) + extra;
    if (broken) hdr_len = (cur_need > 1) ? int'(cur_need) - 2 : 0;
    if ($urandom_range(1) == 0) send_pair(rmfd_pkg::CLS_TWO, rmfd_pkg::CLS_ONE);
    repeat (hdr_len) send_pair(rmfd_pkg::CLS_ONE, rmfd_pkg::CLS_ONE);
    send_pair(rmfd_pkg::CLS_ONE, rmfd_pkg::CLS_TWO);
    body_len = $urandom_range(70, 30);
    repeat (body_len) send_symbol();
  endtask

  task automatic run_traffic(input int n_items);
    int stop_at;
    int pick;
    stop_at = captures_sent + n_items;
    while (captures_sent < stop_at) begin
      pick = $urandom_range(9);
      if (pick < 6) send_frame(pick == 5, $urandom_range(3));
      else if (pick == 6)
        send_capture(rmfd_pkg::TIME_W'($urandom), rmfd_pkg::TIME_W'($urandom));
      else if (pick == 7) send_capture('0, rmfd_pkg::TIME_W'($urandom));
      else send_pair(rmfd_pkg::class_t'($urandom_range(2)),
                     rmfd_pkg::class_t'($urandom_range(2)));
    end
  endtask

  initial begin
    int pick;
    logic [rmfd_pkg::TIME_W-1:0] ht;
    sb = new();
    repeat (11) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    send_idle_pct = 37;
    recv_idle_pct = 60;
    // field extremes, wrapped low time and class bounds at reset values
    send_capture(16'h0000, 16'hFFFF);
    send_capture(16'hFFFF, 16'h0000);
    send_capture(16'hFFFF, 16'hFFFF);
    send_capture(16'h0001, 16'h0002);
    send_capture(16'd582, 16'd236);
    send_capture(16'd1460, 16'd675);
    send_capture(16'd1462, 16'd676);
    send_capture(16'd2492, 16'd1192);
    send_capture(16'd580, 16'd235);
    send_capture(16'd2494, 16'd1193);
    // header, start, data, zero period inside data, noise leaves data mode
    send_pair(rmfd_pkg::CLS_TWO, rmfd_pkg::CLS_ONE);
    repeat (8) send_pair(rmfd_pkg::CLS_ONE, rmfd_pkg::CLS_ONE);
    send_pair(rmfd_pkg::CLS_ONE, rmfd_pkg::CLS_TWO);
    send_pair(rmfd_pkg::CLS_TWO, rmfd_pkg::CLS_TWO);
    send_capture('0, rmfd_pkg::TIME_W'($urandom));
    send_pair(rmfd_pkg::CLS_ONE, rmfd_pkg::CLS_ONE);
    send_pair(rmfd_pkg::CLS_NOISE, rmfd_pkg::CLS_ONE);
    run_traffic(150);

    send_idle_pct = 60;
    recv_idle_pct = 37;
    write_all('{16'd100, 16'd400, 16'd900}, '{16'd150, 16'd500, 16'd1100}, 8'd3);
    run_traffic(120);
    wait_idle();
    run_traffic(130);

    send_idle_pct = 0;
    recv_idle_pct = 0;
    write_all('{16'h0000, 16'h8000, 16'hFFFF}, '{16'h0000, 16'h8000, 16'hFFFF}, 8'd255);
    hold_requests++;
    send_frame(1'b0, 6);

    // inverted bounds: only short high times and an all-ones low time are classed
    write_all('{16'h0000, 16'hFFFF, 16'h00FF}, '{16'hFFFF, 16'h0000, 16'hFFFF}, 8'd255);
    repeat (60) begin
      pick = $urandom_range(3);
      ht = rmfd_pkg::TIME_W'($urandom_range(255));
      case (pick)
        0: send_capture(rmfd_pkg::TIME_W'($urandom), rmfd_pkg::TIME_W'($urandom));
        1: send_capture(ht - 1'b1, ht);
        2: send_capture(16'hFFFE, 16'hFFFF);
        default: send_capture(rmfd_pkg::TIME_W'($urandom), 16'h0000);
      endcase
    end

    write_all('{16'd300, 16'd700, 16'd1000}, '{16'd400, 16'd800, 16'd1200}, 8'd0);
    run_traffic(150);

    wait_idle();
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (sb.pending_decodes.size() != 0) begin
      $error("%0d expected results never arrived", sb.pending_decodes.size());
      sb.fails++;
    end
    $display("summary: %0d captures, %0d results checked, %0d complete frames, %0d starts",
             captures_sent, sb.results_checked, sb.frames_done, sb.starts_done);
    $display("summary: %0d register settings incl. extreme, inverted and zero-header bounds",
             settings_used);
    if (sb.fails == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule
